// ===== sv/ivalu_pkg.sv =====
// ----------------------------------------------------------------------------
// ivalu_pkg
// Shared constants and types of the four-lane int32 vector ALU.
// ----------------------------------------------------------------------------
package ivalu_pkg;

   localparam int WORD_W = 32;
   localparam int LANES  = 4;
   // one quotient bit per divider stage
   localparam int DIV_STEPS = WORD_W;

   localparam logic [3:0] CMD_ADD = 4'd0;
   localparam logic [3:0] CMD_SUB = 4'd1;
   localparam logic [3:0] CMD_MUL = 4'd2;
   localparam logic [3:0] CMD_DIV = 4'd3;
   localparam logic [3:0] CMD_MIN = 4'd4;
   localparam logic [3:0] CMD_MAX = 4'd5;
   localparam logic [3:0] CMD_EQ  = 4'd6;
   localparam logic [3:0] CMD_GT  = 4'd7;
   localparam logic [3:0] CMD_LT  = 4'd8;
   localparam logic [3:0] CMD_NE  = 4'd9;
   localparam logic [3:0] CMD_GE  = 4'd10;
   localparam logic [3:0] CMD_LE  = 4'd11;

   typedef struct packed {
      logic eq;
      logic gt;
      logic lt;
      logic zero;
   } lane_flags_type;

endpackage

// ===== sv/int32x4_vector_alu.sv =====
// ----------------------------------------------------------------------------
// int32x4_vector_alu
// Four-lane signed 32-bit vector ALU with a pipelined divider in each lane.
//
//   channel  | ports   | direction | carries
//   request  | req_*   | in        | command, A and B vectors
//   response | rsp_*   | out       | lane results, predicate, total, flag
//
// One transaction per cycle sustained while rsp_ready is held high; every command
// passes through the 32-stage radix-2 divider pipeline.
// Each stage holds data until the next frees; bubbles collapse, so requests
// are taken while a response waits. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module int32x4_vector_alu (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_command,
   input  logic signed [31:0] req_a_lane0,
   input  logic signed [31:0] req_a_lane1,
   input  logic signed [31:0] req_a_lane2,
   input  logic signed [31:0] req_a_lane3,
   input  logic signed [31:0] req_b_lane0,
   input  logic signed [31:0] req_b_lane1,
   input  logic signed [31:0] req_b_lane2,
   input  logic signed [31:0] req_b_lane3,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_r_lane0,
   output logic signed [31:0] rsp_r_lane1,
   output logic signed [31:0] rsp_r_lane2,
   output logic signed [31:0] rsp_r_lane3,
   output logic               rsp_predicate,
   output logic signed [31:0] rsp_lane_total,
   output logic               rsp_divide_by_zero
);

   localparam int W  = ivalu_pkg::WORD_W;
   localparam int L  = ivalu_pkg::LANES;
   localparam int N  = ivalu_pkg::DIV_STEPS;
   localparam int NO = N + 1;   // output register index

   logic [NO:0]  valid_ff;
   logic [NO:0]  rdy;

   logic         pred_ff  [0:N];
   logic         dz_ff    [0:N];
   logic [W-1:0] total_ff [0:N];

   logic [L-1:0][W-1:0]       a_vec;
   logic [L-1:0][W-1:0]       b_vec;
   logic [L-1:0][W-1:0]       lane_res;
   ivalu_pkg::lane_flags_type [L-1:0] flags;
   logic                      pred_in;
   logic                      dz_in;
   logic [W-1:0]              total_in;

   logic [L-1:0][W-1:0] r_ff;
   logic                rpred_ff;
   logic                rdz_ff;
   logic [W-1:0]        rtotal_ff;

   assign a_vec = {req_a_lane3, req_a_lane2, req_a_lane1, req_a_lane0};
   assign b_vec = {req_b_lane3, req_b_lane2, req_b_lane1, req_b_lane0};

   // a stage may load when empty or when its contents move on
   always_comb begin
      rdy[NO] = ~valid_ff[NO] | rsp_ready;
      for (int k = NO - 1; k >= 0; k--) begin
         rdy[k] = ~valid_ff[k] | rdy[k+1];
      end
   end

   assign req_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k <= NO; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   for (genvar i = 0; i < L; i++) begin : g_lane
      ivalu_lane u_lane (
         .clock   (clock),
         .en      (rdy[N:0]),
         .command (req_command),
         .a       (a_vec[i]),
         .b       (b_vec[i]),
         .flags   (flags[i]),
         .result  (lane_res[i])
      );
   end

   ivalu_merge u_merge (
      .command        (req_command),
      .flags          (flags),
      .a_vec          (a_vec),
      .predicate      (pred_in),
      .divide_by_zero (dz_in),
      .lane_total     (total_in)
   );

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pred_ff[0]  <= pred_in;
         dz_ff[0]    <= dz_in;
         total_ff[0] <= total_in;
      end
      for (int k = 1; k <= N; k++) begin
         if (rdy[k]) begin
            pred_ff[k]  <= pred_ff[k-1];
            dz_ff[k]    <= dz_ff[k-1];
            total_ff[k] <= total_ff[k-1];
         end
      end
      if (rdy[NO]) begin
         r_ff      <= lane_res;
         rpred_ff  <= pred_ff[N];
         rdz_ff    <= dz_ff[N];
         rtotal_ff <= total_ff[N];
      end
   end

   assign rsp_valid          = valid_ff[NO];
   assign rsp_r_lane0        = r_ff[0];
   assign rsp_r_lane1        = r_ff[1];
   assign rsp_r_lane2        = r_ff[2];
   assign rsp_r_lane3        = r_ff[3];
   assign rsp_predicate      = rpred_ff;
   assign rsp_divide_by_zero = rdz_ff;
   assign rsp_lane_total     = rtotal_ff;

   a_dz_no_pred: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> !rsp_predicate)
      else $error("zero-divisor flag together with predicate");

   a_pred_zero_lanes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_predicate |->
         (rsp_r_lane0 == '0) && (rsp_r_lane1 == '0) &&
         (rsp_r_lane2 == '0) && (rsp_r_lane3 == '0))
      else $error("predicate transaction with non-zero lanes");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && (&valid_ff))
      else $error("request stalled while pipeline has room");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

// ===== sv/ivalu_lane.sv =====
// ----------------------------------------------------------------------------
// ivalu_lane
// One lane: combinational ops plus a pipelined restoring divider.
// ----------------------------------------------------------------------------
module ivalu_lane (
   input  logic                                     clock,
   input  logic [ivalu_pkg::DIV_STEPS:0]            en,
   input  logic [3:0]                               command,
   input  logic signed [ivalu_pkg::WORD_W-1:0]      a,
   input  logic signed [ivalu_pkg::WORD_W-1:0]      b,
   output ivalu_pkg::lane_flags_type                flags,
   output logic [ivalu_pkg::WORD_W-1:0]             result
);

   localparam int W = ivalu_pkg::WORD_W;
   localparam int N = ivalu_pkg::DIV_STEPS;

   logic [W-1:0] cheap_ff [0:N];
   logic [W-1:0] rem_ff   [0:N];
   logic [W-1:0] quo_ff   [0:N];
   logic [W-1:0] dvs_ff   [0:N];
   logic         neg_ff   [0:N];
   logic         zero_ff  [0:N];
   logic         isdiv_ff [0:N];

   logic [W-1:0] cheap_in;
   logic [W-1:0] prod;
   logic [W-1:0] mag_a;
   logic [W-1:0] mag_b;
   logic [W-1:0] div_val;

   assign flags.eq   = (a == b);
   assign flags.gt   = (a > b);
   assign flags.lt   = (a < b);
   assign flags.zero = (b == '0);

   assign prod  = a * b;
   assign mag_a = a[W-1] ? (~a + 1'b1) : a;
   assign mag_b = b[W-1] ? (~b + 1'b1) : b;

   always_comb begin
      case (command)
         ivalu_pkg::CMD_ADD: cheap_in = a + b;
         ivalu_pkg::CMD_SUB: cheap_in = a - b;
         ivalu_pkg::CMD_MUL: cheap_in = prod;
         ivalu_pkg::CMD_MIN: cheap_in = (a > b) ? b : a;
         ivalu_pkg::CMD_MAX: cheap_in = (a > b) ? a : b;
         default:            cheap_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         cheap_ff[0] <= cheap_in;
         rem_ff[0]   <= '0;
         quo_ff[0]   <= mag_a;
         dvs_ff[0]   <= mag_b;
         neg_ff[0]   <= a[W-1] ^ b[W-1];
         zero_ff[0]  <= (b == '0);
         isdiv_ff[0] <= (command == ivalu_pkg::CMD_DIV);
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      logic [W:0] trial;
      logic       fits;
      assign trial = {rem_ff[k-1], quo_ff[k-1][W-1]};
      assign fits  = (trial >= {1'b0, dvs_ff[k-1]});

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k]   <= fits ? W'(trial - {1'b0, dvs_ff[k-1]}) : trial[W-1:0];
            quo_ff[k]   <= {quo_ff[k-1][W-2:0], fits};
            dvs_ff[k]   <= dvs_ff[k-1];
            cheap_ff[k] <= cheap_ff[k-1];
            neg_ff[k]   <= neg_ff[k-1];
            zero_ff[k]  <= zero_ff[k-1];
            isdiv_ff[k] <= isdiv_ff[k-1];
         end
      end
   end

   // zero divisor gives zero; INT_MIN / -1 wraps through the negate
   assign div_val = zero_ff[N] ? '0 : (neg_ff[N] ? (~quo_ff[N] + 1'b1) : quo_ff[N]);
   assign result  = isdiv_ff[N] ? div_val : cheap_ff[N];

endmodule

// ===== sv/ivalu_merge.sv =====
// ----------------------------------------------------------------------------
// ivalu_merge
// Combines the lane flags into the predicate and zero-divisor flag; sums A lanes.
// ----------------------------------------------------------------------------
module ivalu_merge (
   input  logic [3:0]                                     command,
   input  ivalu_pkg::lane_flags_type [ivalu_pkg::LANES-1:0] flags,
   input  logic [ivalu_pkg::LANES-1:0][ivalu_pkg::WORD_W-1:0] a_vec,
   output logic                                           predicate,
   output logic                                           divide_by_zero,
   output logic [ivalu_pkg::WORD_W-1:0]                   lane_total
);

   logic all_eq;
   logic all_gt;
   logic all_lt;
   logic any_zero;

   always_comb begin
      all_eq     = 1'b1;
      all_gt     = 1'b1;
      all_lt     = 1'b1;
      any_zero   = 1'b0;
      lane_total = '0;
      for (int i = 0; i < ivalu_pkg::LANES; i++) begin
         all_eq     = all_eq & flags[i].eq;
         all_gt     = all_gt & flags[i].gt;
         all_lt     = all_lt & flags[i].lt;
         any_zero   = any_zero | flags[i].zero;
         lane_total = lane_total + a_vec[i];
      end
   end

   always_comb begin
      case (command)
         ivalu_pkg::CMD_EQ: predicate = all_eq;
         ivalu_pkg::CMD_GT: predicate = all_gt;
         ivalu_pkg::CMD_LT: predicate = all_lt;
         ivalu_pkg::CMD_NE: predicate = ~all_eq;
         ivalu_pkg::CMD_GE: predicate = all_eq | all_gt;
         ivalu_pkg::CMD_LE: predicate = all_eq | all_lt;
         default:           predicate = 1'b0;
      endcase
   end

   assign divide_by_zero = (command == ivalu_pkg::CMD_DIV) & any_zero;

endmodule
